/* sv/stbs_pkg.sv */
// stbs_pkg: request and status codes, field types and the memory control
// struct for the sorted table search block
// depends on nothing
`default_nettype none
package stbs_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 10;

  typedef logic [1:0]              req_t;
  typedef logic [1:0]              status_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic signed [VAL_W-1:0] val_t;

  localparam req_t REQ_CLEAR  = 2'd0;
  localparam req_t REQ_APPEND = 2'd1;
  localparam req_t REQ_SEARCH = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_NOTFOUND = 2'd1;
  localparam status_t ST_FULL     = 2'd2;

  // strobes from the controller to the table memory
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } mem_ctl_t;

endpackage
`default_nettype wire

/* sv/sorted_table_binary_search_top.sv */
// sorted table binary search, one result per transfer in
// a search of k probes has k <= floor(log2(entry count)) + 1, one probe a
// cycle on the single table memory port; the block takes no new transfer
// until the result of the last one has been loaded into the output register
// reset clears the entry count and handshake state; table contents are left
// undefined and are never read before being written, so no clearing pass
`default_nettype none
module sorted_table_binary_search_top #(
  parameter int DEPTH = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire stbs_pkg::req_t    req_type,
  input  wire stbs_pkg::val_t    value,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output stbs_pkg::status_t      status,
  output stbs_pkg::pos_t         position
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  stbs_pkg::mem_ctl_t ctl;
  logic [AW-1:0]      addr;
  stbs_pkg::val_t     wdata;
  stbs_pkg::val_t     rdata;

  // sequencer and result register
  stbs_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .req_type  (req_type),
    .value     (value),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .position  (position),
    .ctl       (ctl),
    .addr      (addr),
    .wdata     (wdata),
    .rdata     (rdata)
  );

  // table storage
  stbs_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .ctl   (ctl),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

`ifndef SYNTHESIS
  // one memory access per cycle on the shared port
  a_one_access: assert property (@(posedge clk) disable iff (rst)
    !(ctl.wr_en && ctl.rd_en))
    else $error("table read and write in the same cycle");

  // a write happens only on an accepted append transfer
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ctl.wr_en |-> (in_valid && !in_stall && req_type == stbs_pkg::REQ_APPEND))
    else $error("table write without an append transfer");

  // the block is busy in the cycle after an accepted transfer
  a_busy_after: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again straight after a transfer");
`endif

endmodule
`default_nettype wire

/* sv/stbs_mem.sv */
// stbs_mem: single port table memory, registered read
// depends on stbs_pkg
`default_nettype none
module stbs_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire stbs_pkg::mem_ctl_t ctl,
  input  wire logic [AW-1:0]     addr,
  input  wire stbs_pkg::val_t    wdata,
  output stbs_pkg::val_t         rdata
);

  stbs_pkg::val_t mem [DEPTH];

  // write or registered read at one address
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[addr] <= wdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule
`default_nettype wire

/* sv/stbs_ctrl.sv */
// stbs_ctrl: request decode, entry count, binary search sequencer and
// result register; drives the table memory
// depends on stbs_pkg
`default_nettype none
module stbs_ctrl #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire stbs_pkg::req_t     req_type,
  input  wire stbs_pkg::val_t     value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output stbs_pkg::status_t       status,
  output stbs_pkg::pos_t          position,
  output stbs_pkg::mem_ctl_t      ctl,
  output logic [AW-1:0]           addr,
  output stbs_pkg::val_t          wdata,
  input  wire stbs_pkg::val_t     rdata
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SRCH = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]        state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [CW-1:0]     lo, lo_next;
  logic [CW-1:0]     hip1, hip1_next;   // high bound plus one
  logic [AW-1:0]     mid, mid_next;
  stbs_pkg::val_t    target, target_next;
  stbs_pkg::status_t res_status, res_status_next;
  stbs_pkg::pos_t    res_pos, res_pos_next;
  logic [CW:0]       mid_sum;
  logic              load_out;

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  // midpoint of the next probe, floor((lo + hi) / 2) with hi = hip1 - 1
  assign mid_sum  = {1'b0, lo_next} + {1'b0, hip1_next} - (CW+1)'(1);
  assign mid_next = mid_sum[AW:1];

  // appends write at the fill count, probes read at the next midpoint
  assign addr  = ctl.wr_en ? count[AW-1:0] : mid_next;
  assign wdata = value;

  // next state and memory strobes
  always_comb begin
    state_next      = state;
    count_next      = count;
    lo_next         = lo;
    hip1_next       = hip1;
    target_next     = target;
    res_status_next = res_status;
    res_pos_next    = res_pos;
    ctl             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = stbs_pkg::ST_OK;
          res_pos_next    = '0;
          state_next      = S_DONE;
          unique case (req_type)
            stbs_pkg::REQ_CLEAR: begin
              count_next = '0;
            end
            stbs_pkg::REQ_APPEND: begin
              if (count < CW'(DEPTH)) begin
                ctl.wr_en    = 1'b1;
                res_pos_next = stbs_pkg::pos_t'(count);
                count_next   = count + CW'(1);
              end else begin
                res_status_next = stbs_pkg::ST_FULL;
              end
            end
            stbs_pkg::REQ_SEARCH: begin
              target_next = value;
              if (count == '0) begin
                res_status_next = stbs_pkg::ST_NOTFOUND;
              end else begin
                lo_next    = '0;
                hip1_next  = count;
                ctl.rd_en  = 1'b1;
                state_next = S_SRCH;
              end
            end
            default: begin
              // unused request code gives ST_OK at position zero and leaves the table alone
            end
          endcase
        end
      end
      S_SRCH: begin
        if (rdata == target) begin
          res_status_next = stbs_pkg::ST_OK;
          res_pos_next    = stbs_pkg::pos_t'(mid);
          state_next      = S_DONE;
        end else begin
          if (rdata > target) begin
            hip1_next = CW'(mid);
          end else begin
            lo_next = CW'(mid) + CW'(1);
          end
          if (lo_next < hip1_next) begin
            ctl.rd_en = 1'b1;
          end else begin
            res_status_next = stbs_pkg::ST_NOTFOUND;
            res_pos_next    = '0;
            state_next      = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // search bounds, target and result payload
  always_ff @(posedge clk) begin
    lo         <= lo_next;
    hip1       <= hip1_next;
    target     <= target_next;
    res_status <= res_status_next;
    res_pos    <= res_pos_next;
    if (ctl.rd_en) begin
      mid <= mid_next;
    end
    if (load_out) begin
      status   <= res_status;
      position <= res_pos;
    end
  end

endmodule
`default_nettype wire
